@@ design/lhp_pkg.sv @@
package lhp_pkg;

	localparam int DOMAINS = 5;
	localparam int FIELDS = 64;
	localparam int BUCKETS = 48;

	localparam int CNT_DEPTH = DOMAINS * FIELDS;
	localparam int HIST_DEPTH = CNT_DEPTH * BUCKETS;
	localparam int DOM_HIST = FIELDS * BUCKETS;
	localparam int CNT_AW = $clog2(CNT_DEPTH);
	localparam int HIST_AW = $clog2(HIST_DEPTH);
	localparam int BKT_W = $clog2(BUCKETS);

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_OBSERVE = 3'd1;
	localparam logic [2:0] OP_READ = 3'd2;
	localparam logic [2:0] OP_QUERY = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [2:0] K_NOP = 3'd0;
	localparam logic [2:0] K_ADD = 3'd1;
	localparam logic [2:0] K_OBS = 3'd2;
	localparam logic [2:0] K_READ = 3'd3;
	localparam logic [2:0] K_QUERY = 3'd4;
	localparam logic [2:0] K_CLEAR = 3'd5;

	typedef struct packed {
		logic [2:0]  operation;
		logic [2:0]  domain;
		logic [5:0]  field;
		logic [63:0] amount;
		logic [31:0] batch_id;
		logic        view_last;
		logic [6:0]  percentile;
	} item_t;

	typedef struct packed {
		logic        status;
		logic [63:0] data;
		logic        present;
		logic [63:0] sample_count;
		logic        found;
		logic [31:0] generation_now;
	} result_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic               reject;
		logic [2:0]         domain;
		logic [5:0]         field;
		logic [CNT_AW-1:0]  cnt_addr;
		logic [HIST_AW-1:0] hist_base;
		logic [BKT_W-1:0]   bucket;
		logic [63:0]        amount;
		logic [31:0]        gen;
		logic               view_last;
		logic [6:0]         pct;
	} cmd_t;

	function automatic logic [BKT_W-1:0] bucket_of(input logic [63:0] v);
		logic [6:0] len;
		len = 7'd0;
		for (int i = 0; i < 64; i++) begin
			if (v[i])
				len = 7'(i + 1);
		end
		if (len > 7'(BUCKETS - 1))
			len = 7'(BUCKETS - 1);
		return BKT_W'(len);
	endfunction

	function automatic logic [63:0] upper_bound(input logic [BKT_W-1:0] b);
		logic [63:0] r;
		if (b == '0)
			r = 64'd0;
		else if (7'(b) >= 7'd64)
			r = '1;
		else
			r = (64'd1 << b) - 64'd1;
		return r;
	endfunction

endpackage

@@ design/lhp_ram.sv @@
module lhp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 320
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

@@ design/lhp_front.sv @@
module lhp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  lhp_pkg::item_t item,
	input  logic           hold,
	output logic           cmd_valid,
	input  logic           cmd_pop,
	output lhp_pkg::cmd_t  cmd
);
	import lhp_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       do_push;
	int         idx;

	always_comb begin
		idx = int'(item.domain) * FIELDS + int'(item.field);
		cls = '0;
		cls.domain = item.domain;
		cls.field = item.field;
		cls.amount = item.amount;
		cls.gen = item.batch_id;
		cls.view_last = item.view_last;
		cls.pct = (item.percentile > 7'd100) ? 7'd100 : item.percentile;
		cls.cnt_addr = CNT_AW'(idx);
		cls.hist_base = HIST_AW'(idx * BUCKETS);
		cls.bucket = bucket_of(item.amount);
		cls.reject = (item.operation <= OP_QUERY) &&
			((4'(item.domain) >= 4'(DOMAINS)) || (7'(item.field) >= 7'(FIELDS)));
		if (cls.reject)
			cls.kind = K_NOP;
		else begin
			case (item.operation)
				OP_ADD:     cls.kind = K_ADD;
				OP_OBSERVE: cls.kind = K_OBS;
				OP_READ:    cls.kind = K_READ;
				OP_QUERY:   cls.kind = K_QUERY;
				OP_CLEAR:   cls.kind = K_CLEAR;
				default:    cls.kind = K_NOP;
			endcase
		end
	end

	assign full = (cnt_q == 2'd2) || hold;
	assign do_push = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (cmd_pop && cmd_valid)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(cmd_pop && cmd_valid);
		end
	end

endmodule

@@ design/lhp_back.sv @@
module lhp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  lhp_pkg::cmd_t    cmd,
	output logic             init_busy,
	output logic             empty,
	input  logic             pop,
	output lhp_pkg::result_t result
);
	import lhp_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_UPD_RD = 4'd2;
	localparam logic [3:0] S_UPD_WR = 4'd3;
	localparam logic [3:0] S_READ_RD = 4'd4;
	localparam logic [3:0] S_READ_WAIT = 4'd5;
	localparam logic [3:0] S_Q_ISS = 4'd6;
	localparam logic [3:0] S_Q_ACC = 4'd7;
	localparam logic [3:0] S_Q_PROD = 4'd8;
	localparam logic [3:0] S_Q_CMP = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0]         state_q;
	cmd_t               cmd_q;
	logic [HIST_AW-1:0] sw_q;
	logic               sw_all_q, init_q, phase_q, found_q, out_full_q;
	logic [BKT_W-1:0]   b_q;
	logic [63:0]        acc_q, samples_q, data_q;
	logic [70:0]        prod_q;
	logic [63:0]        seen_q [DOMAINS];
	logic [63:0]        bseen_q [DOMAINS];
	logic [31:0]        tag_q [DOMAINS];
	result_t            res_q, res_d;

	logic [HIST_AW-1:0] haddr;
	logic [CNT_AW-1:0]  caddr;
	logic               htot_we, hbat_we, ctot_we, cbat_we;
	logic [63:0]        htot_wd, hbat_wd, ctot_wd, cbat_wd;
	logic [63:0]        htot_rd, hbat_rd, ctot_rd, cbat_rd, hsel;
	logic               sw_last, clearing;

	lhp_ram #(.WIDTH(64), .DEPTH(HIST_DEPTH)) u_htot (
		.clk(clk), .addr(haddr), .we(htot_we), .wdata(htot_wd), .rdata(htot_rd));
	lhp_ram #(.WIDTH(64), .DEPTH(HIST_DEPTH)) u_hbat (
		.clk(clk), .addr(haddr), .we(hbat_we), .wdata(hbat_wd), .rdata(hbat_rd));
	lhp_ram #(.WIDTH(64), .DEPTH(CNT_DEPTH)) u_ctot (
		.clk(clk), .addr(caddr), .we(ctot_we), .wdata(ctot_wd), .rdata(ctot_rd));
	lhp_ram #(.WIDTH(64), .DEPTH(CNT_DEPTH)) u_cbat (
		.clk(clk), .addr(caddr), .we(cbat_we), .wdata(cbat_wd), .rdata(cbat_rd));

	assign clearing = (state_q == S_CLEAR);
	assign hsel = cmd_q.view_last ? hbat_rd : htot_rd;
	assign sw_last = sw_all_q ? (sw_q == HIST_AW'(HIST_DEPTH - 1))
		: (sw_q == HIST_AW'(DOM_HIST - 1));
	assign cmd_pop = (state_q == S_IDLE) && !init_q && cmd_valid;
	assign init_busy = init_q;
	assign empty = !out_full_q;
	assign result = res_q;

	always_comb begin
		haddr = cmd_q.hist_base + HIST_AW'(cmd_q.bucket);
		caddr = cmd_q.cnt_addr;
		htot_we = 1'b0;
		hbat_we = 1'b0;
		ctot_we = 1'b0;
		cbat_we = 1'b0;
		htot_wd = htot_rd + 64'd1;
		hbat_wd = hbat_rd + 64'd1;
		ctot_wd = ctot_rd + cmd_q.amount;
		cbat_wd = cbat_rd + cmd_q.amount;
		case (state_q)
			S_CLEAR: begin
				htot_wd = '0;
				hbat_wd = '0;
				ctot_wd = '0;
				cbat_wd = '0;
				if (sw_all_q) begin
					haddr = sw_q;
					caddr = CNT_AW'(sw_q);
					htot_we = 1'b1;
					hbat_we = 1'b1;
					ctot_we = (sw_q < HIST_AW'(CNT_DEPTH));
					cbat_we = (sw_q < HIST_AW'(CNT_DEPTH));
				end else begin
					haddr = HIST_AW'(int'(cmd_q.domain) * DOM_HIST) + sw_q;
					caddr = CNT_AW'(int'(cmd_q.domain) * FIELDS) + CNT_AW'(sw_q);
					hbat_we = 1'b1;
					cbat_we = (sw_q < HIST_AW'(FIELDS));
				end
			end
			S_UPD_WR: begin
				ctot_we = 1'b1;
				cbat_we = 1'b1;
				htot_we = (cmd_q.kind == K_OBS);
				hbat_we = (cmd_q.kind == K_OBS);
			end
			S_Q_ISS:
				haddr = cmd_q.hist_base + HIST_AW'(b_q);
			default: ;
		endcase
	end

	always_comb begin
		res_d = '0;
		res_d.status = cmd_q.reject;
		if (cmd_q.kind != K_NOP && cmd_q.kind != K_CLEAR) begin
			res_d.data = data_q;
			res_d.found = found_q;
			res_d.sample_count = (cmd_q.kind == K_QUERY) ? samples_q : 64'd0;
			res_d.present = cmd_q.view_last ? bseen_q[cmd_q.domain][cmd_q.field]
				: seen_q[cmd_q.domain][cmd_q.field];
			res_d.generation_now = tag_q[cmd_q.domain];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cmd_q <= cmd;
		if (state_q == S_DONE && (!out_full_q || pop))
			res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			init_q <= 1'b1;
			sw_all_q <= 1'b1;
			sw_q <= '0;
			out_full_q <= 1'b0;
			phase_q <= 1'b0;
			found_q <= 1'b0;
			b_q <= '0;
			acc_q <= '0;
			samples_q <= '0;
			data_q <= '0;
			prod_q <= '0;
			for (int i = 0; i < DOMAINS; i++) begin
				seen_q[i] <= '0;
				bseen_q[i] <= '0;
				tag_q[i] <= '0;
			end
		end else begin
			// a result that is loaded in S_DONE keeps the flag set
			if (pop && out_full_q && (state_q != S_DONE))
				out_full_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						data_q <= '0;
						found_q <= 1'b0;
						samples_q <= '0;
						sw_q <= '0;
						case (cmd.kind)
							K_CLEAR: begin
								sw_all_q <= 1'b1;
								state_q <= S_CLEAR;
							end
							K_ADD, K_OBS: begin
								sw_all_q <= 1'b0;
								state_q <= (tag_q[cmd.domain] != cmd.gen) ? S_CLEAR : S_UPD_RD;
							end
							K_READ:
								state_q <= S_READ_RD;
							K_QUERY: begin
								b_q <= '0;
								acc_q <= '0;
								phase_q <= 1'b0;
								state_q <= S_Q_ISS;
							end
							default:
								state_q <= S_DONE;
						endcase
					end
				end
				S_CLEAR: begin
					sw_q <= sw_q + HIST_AW'(1);
					if (sw_last) begin
						if (sw_all_q) begin
							for (int i = 0; i < DOMAINS; i++) begin
								seen_q[i] <= '0;
								bseen_q[i] <= '0;
								tag_q[i] <= '0;
							end
							init_q <= 1'b0;
							state_q <= init_q ? S_IDLE : S_DONE;
						end else begin
							bseen_q[cmd_q.domain] <= '0;
							tag_q[cmd_q.domain] <= cmd_q.gen;
							state_q <= S_UPD_RD;
						end
					end
				end
				S_UPD_RD:
					state_q <= S_UPD_WR;
				S_UPD_WR: begin
					seen_q[cmd_q.domain][cmd_q.field] <= 1'b1;
					bseen_q[cmd_q.domain][cmd_q.field] <= 1'b1;
					state_q <= S_DONE;
				end
				S_READ_RD:
					state_q <= S_READ_WAIT;
				S_READ_WAIT: begin
					data_q <= cmd_q.view_last ? cbat_rd : ctot_rd;
					state_q <= S_DONE;
				end
				S_Q_ISS:
					state_q <= S_Q_ACC;
				S_Q_ACC: begin
					acc_q <= acc_q + hsel;
					if (phase_q)
						state_q <= S_Q_CMP;
					else if (b_q == BKT_W'(BUCKETS - 1)) begin
						samples_q <= acc_q + hsel;
						state_q <= S_Q_PROD;
					end else begin
						b_q <= b_q + BKT_W'(1);
						state_q <= S_Q_ISS;
					end
				end
				S_Q_PROD: begin
					prod_q <= 71'(samples_q) * 71'(cmd_q.pct);
					acc_q <= '0;
					b_q <= '0;
					phase_q <= 1'b1;
					state_q <= (samples_q == 64'd0) ? S_DONE : S_Q_ISS;
				end
				S_Q_CMP: begin
					if ((71'(acc_q) * 71'd100) >= prod_q) begin
						data_q <= upper_bound(b_q);
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else if (b_q == BKT_W'(BUCKETS - 1))
						state_q <= S_DONE;
					else begin
						b_q <= b_q + BKT_W'(1);
						state_q <= S_Q_ISS;
					end
				end
				S_DONE: begin
					if (!out_full_q || pop) begin
						out_full_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default:
					state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !cmd_pop) else $error("command taken during clear sweep");
	a_init_clear: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> clearing) else $error("init pass left clear state");
	a_upd_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD_WR) |-> (ctot_we && cbat_we)) else $error("update without write");
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && !out_full_q) |=> out_full_q)
		else $error("result not loaded");
`endif

endmodule

@@ design/latency_histogram_profiler_top.sv @@
// Latency histogram profiler: queue-style ports on both sides, one result per
// transaction. After reset a clearing pass sweeps all 15360 histogram rows
// with full held high. A batch generation change on add or observe adds a
// sweep of the domain's batch side; clear-all sweeps all rows again; a
// percentile query walks the histogram twice through the single-port bucket
// memory, the second walk stopping at the hit bucket (once only with no
// samples). The back end works on one transaction at a time; a two-entry
// command queue and the result register let the input and output sides stall
// independently.
module latency_histogram_profiler_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  lhp_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output lhp_pkg::result_t result
);
	import lhp_pkg::*;

	logic cmd_valid, cmd_pop, init_busy;
	cmd_t cmd;

	lhp_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.hold(init_busy), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd));

	lhp_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
		.cmd(cmd), .init_busy(init_busy), .empty(empty), .pop(pop), .result(result));

endmodule
